>>> design/tac_pkg.sv
package tac_pkg;

  // request and result field widths
  localparam int REQ_ADDR_W = 5;
  localparam int OPC_W      = 4;
  localparam int OPND_W     = 8;
  localparam int IO_W       = 32;
  localparam int PC_OUT_W   = 5;
  localparam int INSN_W     = OPC_W + OPND_W;
  localparam int OPND_CNT   = 1 << OPND_W;
  localparam int ADDR_CNT   = 1 << REQ_ADDR_W;

  // request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD  = 4'd1,
    OP_ADD   = 4'd2,
    OP_STORE = 4'd3,
    OP_SUB   = 4'd4,
    OP_IN    = 4'd5,
    OP_OUT   = 4'd6,
    OP_END   = 4'd7,
    OP_JMP   = 4'd8,
    OP_SKIPZ = 4'd9
  } op_t;

  typedef struct packed {
    logic                  req_type;
    logic [REQ_ADDR_W-1:0] prog_addr;
    logic [OPC_W-1:0]      prog_opcode;
    logic [OPND_W-1:0]     prog_operand;
    logic signed [IO_W-1:0] in_value;
  } tac_req_t;

  typedef struct packed {
    logic [PC_OUT_W-1:0]    pc_now;
    logic signed [IO_W-1:0] acc_now;
    logic                   out_strobe;
    logic signed [IO_W-1:0] out_value;
    logic                   in_taken;
    logic                   halted_flag;
    logic [OPND_W-1:0]      halt_status;
    logic                   illegal_op;
  } tac_rsp_t;

  // side effects of one executed instruction
  typedef struct packed {
    logic out_strobe;
    logic in_taken;
    logic illegal;
    logic st_we;
    logic halt_set;
  } tac_flags_t;

endpackage

>>> design/tac_if.sv
interface tac_in_if import tac_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [REQ_ADDR_W-1:0]  prog_addr;
  logic [OPC_W-1:0]       prog_opcode;
  logic [OPND_W-1:0]      prog_operand;
  logic signed [IO_W-1:0] in_value;

  modport source (
    output valid, req_type, prog_addr, prog_opcode, prog_operand, in_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, prog_addr, prog_opcode, prog_operand, in_value,
    output ready
  );
endinterface

interface tac_out_if import tac_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [PC_OUT_W-1:0]    pc_now;
  logic signed [IO_W-1:0] acc_now;
  logic                   out_strobe;
  logic signed [IO_W-1:0] out_value;
  logic                   in_taken;
  logic                   halted_flag;
  logic [OPND_W-1:0]      halt_status;
  logic                   illegal_op;

  modport source (
    output valid, pc_now, acc_now, out_strobe, out_value, in_taken, halted_flag,
           halt_status, illegal_op,
    input  ready
  );
  modport sink (
    input  valid, pc_now, acc_now, out_strobe, out_value, in_taken, halted_flag,
           halt_status, illegal_op,
    output ready
  );
endinterface

>>> design/tac_exec.sv
module tac_exec import tac_pkg::*; #(
  parameter int PROG_DEPTH = 32,
  parameter int WORD_BITS  = 32,
  localparam int PC_W = $clog2(PROG_DEPTH)
) (
  input  logic                        step,
  input  logic [OPC_W-1:0]            opcode,
  input  logic [OPND_W-1:0]           operand,
  input  logic [PC_W-1:0]             pc,
  input  logic signed [WORD_BITS-1:0] acc,
  input  logic signed [WORD_BITS-1:0] dmem_rd,
  input  logic signed [WORD_BITS-1:0] in_word,
  output logic [PC_W-1:0]             pc_nxt,
  output logic signed [WORD_BITS-1:0] acc_nxt,
  output tac_flags_t                  flags
);

  logic [PC_W-1:0] jmp_tbl [OPND_CNT];
  logic [PC_W-1:0] pc_inc;
  logic [PC_W-1:0] pc_inc2;

  // jump targets wrap modulo the program depth
  for (genvar g = 0; g < OPND_CNT; g++) begin : g_jmp
    assign jmp_tbl[g] = PC_W'(g % PROG_DEPTH);
  end

  assign pc_inc  = (pc == PC_W'(PROG_DEPTH - 1)) ? '0 : pc + 1'b1;
  assign pc_inc2 = (pc_inc == PC_W'(PROG_DEPTH - 1)) ? '0 : pc_inc + 1'b1;

  always_comb begin
    pc_nxt  = pc;
    acc_nxt = acc;
    flags   = '0;
    if (step) begin
      pc_nxt = pc_inc;
      unique case (op_t'(opcode))
        OP_LOAD:  acc_nxt = dmem_rd;
        OP_ADD:   acc_nxt = acc + dmem_rd;
        OP_STORE: flags.st_we = 1'b1;
        OP_SUB:   acc_nxt = acc - dmem_rd;
        OP_IN: begin
          acc_nxt        = in_word;
          flags.in_taken = 1'b1;
        end
        OP_OUT:   flags.out_strobe = 1'b1;
        OP_END:   flags.halt_set = 1'b1;
        OP_JMP:   pc_nxt = jmp_tbl[operand];
        OP_SKIPZ: begin
          if (acc == '0) begin
            pc_nxt = pc_inc2;
          end
        end
        default:  flags.illegal = 1'b1;
      endcase
    end
  end

endmodule

>>> design/tiny_accumulator_cpu.sv
// A request goes through the request register, then execution, then the result register.
// Throughput: one request per cycle unless stalled; a stall holds back at most one request.
// Each step does fetch, data read, add/subtract and write-back between the two registers.
// Reset (rst_n low, synchronous) clears pc, accumulator, halt state, both stores
// and the pipeline valids; requests are taken as soon as reset is released.
module tiny_accumulator_cpu import tac_pkg::*; #(
  parameter int PROG_DEPTH = 32,
  parameter int DATA_DEPTH = 16,
  parameter int WORD_BITS  = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  tac_in_if.sink   in_chan,
  tac_out_if.source out_chan
);

  localparam int PC_W = $clog2(PROG_DEPTH);
  localparam int DA_W = $clog2(DATA_DEPTH);

  tac_req_t                    req_r;
  logic                        req_vld_r;
  tac_rsp_t                    rsp_r;
  tac_rsp_t                    rsp_nxt;
  logic                        out_vld_r;

  logic [INSN_W-1:0]           prog_mem_r [PROG_DEPTH];
  logic [WORD_BITS-1:0]        data_mem_r [DATA_DEPTH];
  logic [PC_W-1:0]             pc_r;
  logic signed [WORD_BITS-1:0] acc_r;
  logic                        halted_r;
  logic [OPND_W-1:0]           halt_code_r;

  logic [PC_W-1:0]             pa_tbl [ADDR_CNT];
  logic [DA_W-1:0]             da_tbl [OPND_CNT];

  logic                        out_free;
  logic                        exec_en;
  logic                        step;
  logic [INSN_W-1:0]           insn;
  logic [OPC_W-1:0]            opcode;
  logic [OPND_W-1:0]           operand;
  logic [DA_W-1:0]             da;
  logic signed [WORD_BITS-1:0] dmem_rd;
  logic signed [WORD_BITS-1:0] in_word;
  logic [PC_W-1:0]             pc_nxt;
  logic signed [WORD_BITS-1:0] acc_nxt;
  tac_flags_t                  flags;
  logic                        halted_nxt;
  logic [OPND_W-1:0]           halt_code_nxt;

  // address wrap tables
  for (genvar g = 0; g < ADDR_CNT; g++) begin : g_pa
    assign pa_tbl[g] = PC_W'(g % PROG_DEPTH);
  end
  for (genvar g = 0; g < OPND_CNT; g++) begin : g_da
    assign da_tbl[g] = DA_W'(g % DATA_DEPTH);
  end

  assign out_free      = !out_vld_r || out_chan.ready;
  assign exec_en       = req_vld_r && out_free;
  assign in_chan.ready = !req_vld_r || out_free;

  assign step    = (req_r.req_type == REQ_STEP) && !halted_r;
  assign insn    = prog_mem_r[pc_r];
  assign opcode  = insn[INSN_W-1:OPND_W];
  assign operand = insn[OPND_W-1:0];
  assign da      = da_tbl[operand];
  assign dmem_rd = signed'(data_mem_r[da]);
  assign in_word = WORD_BITS'(signed'(req_r.in_value));

  tac_exec #(
    .PROG_DEPTH (PROG_DEPTH),
    .WORD_BITS  (WORD_BITS)
  ) u_exec (
    .step    (step),
    .opcode  (opcode),
    .operand (operand),
    .pc      (pc_r),
    .acc     (acc_r),
    .dmem_rd (dmem_rd),
    .in_word (in_word),
    .pc_nxt  (pc_nxt),
    .acc_nxt (acc_nxt),
    .flags   (flags)
  );

  assign halted_nxt    = halted_r || flags.halt_set;
  assign halt_code_nxt = flags.halt_set ? operand : halt_code_r;

  always_comb begin
    rsp_nxt             = '0;
    rsp_nxt.pc_now      = PC_OUT_W'(pc_nxt);
    rsp_nxt.acc_now     = IO_W'(acc_nxt);
    rsp_nxt.out_strobe  = flags.out_strobe;
    rsp_nxt.out_value   = flags.out_strobe ? IO_W'(acc_r) : '0;
    rsp_nxt.in_taken    = flags.in_taken;
    rsp_nxt.halted_flag = halted_nxt;
    rsp_nxt.halt_status = halt_code_nxt;
    rsp_nxt.illegal_op  = flags.illegal;
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      req_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      req_r.req_type     <= in_chan.req_type;
      req_r.prog_addr    <= in_chan.prog_addr;
      req_r.prog_opcode  <= in_chan.prog_opcode;
      req_r.prog_operand <= in_chan.prog_operand;
      req_r.in_value     <= in_chan.in_value;
    end
  end

  // architectural state and stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      acc_r       <= '0;
      halted_r    <= 1'b0;
      halt_code_r <= '0;
      for (int i = 0; i < PROG_DEPTH; i++) begin
        prog_mem_r[i] <= '0;
      end
      for (int i = 0; i < DATA_DEPTH; i++) begin
        data_mem_r[i] <= '0;
      end
    end else if (exec_en) begin
      pc_r        <= pc_nxt;
      acc_r       <= acc_nxt;
      halted_r    <= halted_nxt;
      halt_code_r <= halt_code_nxt;
      if (req_r.req_type == REQ_WRITE) begin
        prog_mem_r[pa_tbl[req_r.prog_addr]] <= {req_r.prog_opcode, req_r.prog_operand};
      end
      if (flags.st_we) begin
        data_mem_r[da] <= acc_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.pc_now      = rsp_r.pc_now;
  assign out_chan.acc_now     = rsp_r.acc_now;
  assign out_chan.out_strobe  = rsp_r.out_strobe;
  assign out_chan.out_value   = rsp_r.out_value;
  assign out_chan.in_taken    = rsp_r.in_taken;
  assign out_chan.halted_flag = rsp_r.halted_flag;
  assign out_chan.halt_status = rsp_r.halt_status;
  assign out_chan.illegal_op  = rsp_r.illegal_op;

endmodule

>>> design/tac_chk.sv
module tac_chk import tac_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_strobe,
  input logic signed [IO_W-1:0] out_value,
  input logic                   in_taken,
  input logic                   halted_flag,
  input logic [OPND_W-1:0]      halt_status,
  input logic                   illegal_op
);

  logic              seen_halt_r;
  logic [OPND_W-1:0] halt_status_r;

  // remember the first halted result that went out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_halt_r <= 1'b0;
    end else if (out_valid && out_ready && halted_flag) begin
      seen_halt_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready && halted_flag && !seen_halt_r) begin
      halt_status_r <= halt_status;
    end
  end

  a_rst_clears_valid: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_strobe)
      && $stable(halted_flag))
    else $error("stalled result changed");

  a_unused_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_strobe |-> out_value == '0)
    else $error("out_value nonzero without strobe");

  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && illegal_op |-> !out_strobe && !in_taken && !halted_flag)
    else $error("illegal opcode had side effects");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_halt_r |-> halted_flag && !out_strobe && !in_taken && !illegal_op
      && halt_status == halt_status_r)
    else $error("activity after halt");

endmodule

bind tiny_accumulator_cpu tac_chk u_tac_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_strobe  (out_chan.out_strobe),
  .out_value   (out_chan.out_value),
  .in_taken    (out_chan.in_taken),
  .halted_flag (out_chan.halted_flag),
  .halt_status (out_chan.halt_status),
  .illegal_op  (out_chan.illegal_op)
);

>>> sim/tb_tiny_accumulator_cpu.sv
module tb_tiny_accumulator_cpu;
  import tac_pkg::*;

  localparam int PROG_WORDS   = 32;
  localparam int DATA_WORDS   = 16;
  localparam int RANDOM_REQS  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int SHOWN_ERRORS = 10;

  // opcodes outside the instruction set
  localparam logic [OPC_W-1:0] OPC_BLANK        = 4'd0;
  localparam logic [OPC_W-1:0] OPC_FIRST_UNUSED = 4'd10;
  localparam logic [OPC_W-1:0] OPC_TOP          = 4'd15;

  typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst_n;

  tac_in_if  in_chan ();
  tac_out_if out_chan ();

  tiny_accumulator_cpu DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // machine state as the block should hold it
  logic [INSN_W-1:0]   prog_mem [PROG_WORDS];
  logic [IO_W-1:0]     data_mem [DATA_WORDS];
  logic [PC_OUT_W-1:0] cpu_pc;
  logic [IO_W-1:0]     cpu_acc;
  logic                cpu_halted;
  logic [OPND_W-1:0]   cpu_halt_code;

  tac_req_t request_q[$];
  tac_rsp_t expected_rsp_q[$];

  int n_writes;
  int n_steps;
  int n_outs;
  int n_ins;
  int n_illegal;
  int n_results;
  int mismatches;
  int cycle_count;
  int gap_left;
  int burst_left;
  int stall_left;
  rx_mode_t rx_mode;

  function automatic tac_rsp_t cpu_next_result(input tac_req_t req);
    tac_rsp_t rsp;
    logic [OPC_W-1:0]  opc;
    logic [OPND_W-1:0] opnd;
    int da;
    rsp = '0;
    if (req.req_type == REQ_WRITE) begin
      prog_mem[req.prog_addr] = {req.prog_opcode, req.prog_operand};
      n_writes++;
    end else if (!cpu_halted) begin
      {opc, opnd} = prog_mem[cpu_pc];
      da = opnd % DATA_WORDS;
      cpu_pc = cpu_pc + 1'b1;  // wraps at the end of the program store
      n_steps++;
      case (opc)
        OP_LOAD:  cpu_acc = data_mem[da];
        OP_ADD:   cpu_acc = cpu_acc + data_mem[da];
        OP_STORE: data_mem[da] = cpu_acc;
        OP_SUB:   cpu_acc = cpu_acc - data_mem[da];
        OP_IN: begin
          cpu_acc = req.in_value;
          rsp.in_taken = 1'b1;
          n_ins++;
        end
        OP_OUT: begin
          rsp.out_strobe = 1'b1;
          rsp.out_value = cpu_acc;
          n_outs++;
        end
        OP_END: begin
          cpu_halted = 1'b1;
          cpu_halt_code = opnd;
        end
        OP_JMP:   cpu_pc = PC_OUT_W'(opnd % PROG_WORDS);
        OP_SKIPZ: if (cpu_acc == '0) cpu_pc = cpu_pc + 1'b1;
        default: begin
          rsp.illegal_op = 1'b1;
          n_illegal++;
        end
      endcase
    end
    rsp.pc_now = cpu_pc;
    rsp.acc_now = cpu_acc;
    rsp.halted_flag = cpu_halted;
    rsp.halt_status = cpu_halt_code;
    return rsp;
  endfunction

  function automatic void queue_write(input int addr, input logic [OPC_W-1:0] opc,
                                      input int opnd);
    tac_req_t r;
    r = '0;
    r.req_type = REQ_WRITE;
    r.prog_addr = addr[REQ_ADDR_W-1:0];
    r.prog_opcode = opc;
    r.prog_operand = opnd[OPND_W-1:0];
    r.in_value = $urandom();  // don't care on a write
    request_q.push_back(r);
  endfunction

  function automatic void queue_step(input logic [IO_W-1:0] value);
    tac_req_t r;
    r = '0;
    r.req_type = REQ_STEP;
    r.prog_addr = REQ_ADDR_W'($urandom());
    r.prog_opcode = OPC_W'($urandom());
    r.prog_operand = OPND_W'($urandom());
    r.in_value = value;
    request_q.push_back(r);
  endfunction

  task automatic check_field(input string field, input logic [IO_W-1:0] want,
                             input logic [IO_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
        $display("result %0d %s: expected %h, got %h", n_results, field, want, got);
    end
  endtask

  // request side: bursts with random gaps
  always @(posedge clk) begin : driver
    logic hold;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        expected_rsp_q.push_back(cpu_next_result(request_q.pop_front()));
      hold = in_chan.valid && !in_chan.ready;
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_chan.valid <= 1'b1;
          in_chan.req_type <= request_q[0].req_type;
          in_chan.prog_addr <= request_q[0].prog_addr;
          in_chan.prog_opcode <= request_q[0].prog_opcode;
          in_chan.prog_operand <= request_q[0].prog_operand;
          in_chan.in_value <= request_q[0].in_value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // result side: compare, then pick the next ready
  always @(posedge clk) begin : monitor
    tac_rsp_t got;
    tac_rsp_t want;
    logic rdy;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left = 0;
      rx_mode = RX_FREE;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.pc_now = out_chan.pc_now;
        got.acc_now = out_chan.acc_now;
        got.out_strobe = out_chan.out_strobe;
        got.out_value = out_chan.out_value;
        got.in_taken = out_chan.in_taken;
        got.halted_flag = out_chan.halted_flag;
        got.halt_status = out_chan.halt_status;
        got.illegal_op = out_chan.illegal_op;
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("result %0d arrived with no request outstanding", n_results);
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("pc_now", want.pc_now, got.pc_now);
          check_field("acc_now", want.acc_now, got.acc_now);
          check_field("out_strobe", want.out_strobe, got.out_strobe);
          check_field("out_value", want.out_value, got.out_value);
          check_field("in_taken", want.in_taken, got.in_taken);
          check_field("halted_flag", want.halted_flag, got.halted_flag);
          check_field("halt_status", want.halt_status, got.halt_status);
          check_field("illegal_op", want.illegal_op, got.illegal_op);
        end
        n_results++;
      end
      if (stall_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        stall_left = $urandom_range(20, 80);
      end else begin
        stall_left--;
      end
      case (rx_mode)
        RX_FREE:   rdy = 1'b1;
        RX_RANDOM: rdy = ($urandom_range(0, 3) != 0);
        default:   rdy = (stall_left % 3 == 0);
      endcase
      out_chan.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests still pending", cycle_count,
               request_q.size() + expected_rsp_q.size());
      $display("FAIL tiny_accumulator_cpu");
      $finish;
    end
  end

  initial begin
    int pick;
    logic [OPC_W-1:0] opc;
    logic [IO_W-1:0]  value;

    cpu_pc = '0;
    cpu_acc = '0;
    cpu_halted = 1'b0;
    cpu_halt_code = '0;
    for (int i = 0; i < PROG_WORDS; i++) prog_mem[i] = '0;
    for (int i = 0; i < DATA_WORDS; i++) data_mem[i] = '0;
    n_writes = 0;
    n_steps = 0;
    n_outs = 0;
    n_ins = 0;
    n_illegal = 0;
    n_results = 0;
    mismatches = 0;
    cycle_count = 0;

    in_chan.valid = 1'b0;
    in_chan.req_type = REQ_WRITE;
    in_chan.prog_addr = '0;
    in_chan.prog_opcode = '0;
    in_chan.prog_operand = '0;
    in_chan.in_value = '0;
    out_chan.ready = 1'b0;
    rst_n = 1'b0;

    // directed: blank word after reset, overflow, skip and jump wrap
    queue_step(32'h8000_0000);
    queue_write(1, OP_IN, 0);
    queue_write(2, OP_STORE, 3);
    queue_write(3, OP_IN, 255);
    queue_write(4, OP_ADD, 19);      // data address wraps to 3
    queue_write(5, OP_OUT, 0);
    queue_write(6, OP_SUB, 3);
    queue_write(7, OP_LOAD, 255);    // never written, reads zero
    queue_write(8, OP_SKIPZ, 0);
    queue_write(9, OPC_TOP, 0);
    queue_write(10, OPC_FIRST_UNUSED, 128);
    queue_write(11, OP_JMP, 255);    // target wraps to 31
    queue_write(31, OP_SKIPZ, 0);    // skip past the end lands on 1
    queue_step(32'h7fff_ffff);
    queue_step($urandom());
    queue_step(32'h0000_0001);
    for (int i = 0; i < 7; i++) queue_step($urandom());

    // random program edits mixed with execution; no halt yet
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if ($urandom_range(0, 99) < 30) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          opc = $urandom_range(0, 1) ? OPC_BLANK
                                     : OPC_W'(OPC_FIRST_UNUSED + $urandom_range(0, 5));
        end else begin
          case ($urandom_range(0, 7))
            0: opc = OP_LOAD;
            1: opc = OP_ADD;
            2: opc = OP_STORE;
            3: opc = OP_SUB;
            4: opc = OP_IN;
            5: opc = OP_OUT;
            6: opc = OP_JMP;
            default: opc = OP_SKIPZ;
          endcase
        end
        queue_write($urandom_range(0, PROG_WORDS - 1), opc, $urandom_range(0, 255));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 2) value = '0;
        else if (pick == 2) value = 32'h8000_0000;
        else if (pick == 3) value = 32'h7fff_ffff;
        else value = $urandom();
        queue_step(value);
      end
    end

    // halt, then requests against a halted machine
    for (int a = 0; a < PROG_WORDS; a++) queue_write(a, OP_END, $urandom_range(1, 255));
    for (int i = 0; i < 4; i++) queue_step($urandom());
    queue_write(0, OP_LOAD, $urandom_range(0, 255));
    for (int i = 0; i < 2; i++) queue_step($urandom());

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (request_q.size() != 0 || expected_rsp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d results: %0d program writes, %0d instructions executed", n_results,
             n_writes, n_steps);
    $display("%0d OUT, %0d IN, %0d illegal opcodes; halt status %0d; %0d mismatches",
             n_outs, n_ins, n_illegal, cpu_halt_code, mismatches);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("PASS tiny_accumulator_cpu");
    end else begin
      $display("FAIL tiny_accumulator_cpu");
    end
    $finish;
  end

endmodule
